[design/fhpc_pkg.sv]
// Shared types, codes and constant tables for the fuzzy heater power controller.
// No dependencies; imported by fhpc_divider and the top level.
package fhpc_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_ACC,
        ST_MODE,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_BOOST     = 3'd1,
        MODE_CUT       = 3'd2,
        MODE_RECOVERED = 3'd4
    } t_mode;

    localparam logic [2:0] CFG_LIMIT_NO_FLOW  = 3'd0;
    localparam logic [2:0] CFG_LIMIT_LOW_FLOW = 3'd1;
    localparam logic [2:0] CFG_LIMIT_MID_FLOW = 3'd2;
    localparam logic [2:0] CFG_HOT_THRESHOLD  = 3'd3;

    localparam int NUM_W = 18;
    localparam int DSR_W = 18;

    typedef struct packed {
        logic              neg;
        logic [NUM_W-1:0]  mag;
        logic [DSR_W-1:0]  dsor;
    } t_fuzzy;

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

    // Fuzzy step as numerator magnitude, sign and divisor 10000 * segment width, or 10000 at or past +-30.
    function automatic t_fuzzy fuzzy_num(input logic signed [11:0] e);
        t_fuzzy            r;
        logic signed [19:0] num;
        logic signed [15:0] lo_out;
        logic signed [15:0] hi_out;
        logic signed [6:0]  p_lo;
        logic signed [6:0]  p_hi;
        logic signed [6:0]  es;
        logic [DSR_W-1:0]   d;
        es     = e[6:0];
        lo_out = 16'sd0;
        hi_out = 16'sd0;
        p_lo   = 7'sd0;
        p_hi   = 7'sd0;
        d      = DSR_W'(10000);
        num    = 20'sd0;
        priority if (e <= -12'sd80 || e >= 12'sd80) begin
            num = signed'(20'(e)) * 20'sd100;
        end else if (e <= -12'sd30) begin
            num = -20'sd7500;
        end else if (e >= 12'sd30) begin
            num = 20'sd10000;
        end else begin
            priority if (e <= -12'sd15) begin
                lo_out = -16'sd7500; hi_out = -16'sd3500;
                p_lo = -7'sd30; p_hi = -7'sd15; d = DSR_W'(150000);
            end else if (e <= -12'sd5) begin
                lo_out = -16'sd3500; hi_out = -16'sd900;
                p_lo = -7'sd15; p_hi = -7'sd5; d = DSR_W'(100000);
            end else if (e <= 12'sd0) begin
                lo_out = -16'sd900; hi_out = 16'sd100;
                p_lo = -7'sd5; p_hi = 7'sd0; d = DSR_W'(50000);
            end else if (e <= 12'sd5) begin
                lo_out = 16'sd100; hi_out = 16'sd1000;
                p_lo = 7'sd0; p_hi = 7'sd5; d = DSR_W'(50000);
            end else if (e <= 12'sd15) begin
                lo_out = 16'sd1000; hi_out = 16'sd5000;
                p_lo = 7'sd5; p_hi = 7'sd15; d = DSR_W'(100000);
            end else begin
                lo_out = 16'sd5000; hi_out = 16'sd10000;
                p_lo = 7'sd15; p_hi = 7'sd30; d = DSR_W'(150000);
            end
            num = signed'(20'(lo_out)) * signed'(20'(p_hi - es))
                + signed'(20'(hi_out)) * signed'(20'(es - p_lo));
        end
        r.neg  = num[19];
        r.mag  = num[19] ? NUM_W'(-num) : NUM_W'(num);
        r.dsor = d;
        return r;
    endfunction

endpackage

[design/fhpc_divider.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on fhpc_pkg for the control struct.
module fhpc_divider
    import fhpc_pkg::*;
#(
    parameter int NW = 28,
    parameter int DW = 19
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_div_ctl      i_ctl,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output t_div_ctl      o_ctl,
    output logic [NW-1:0] o_quotient
);
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_dsor;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_quo[NW-1]};
    assign fits  = trial >= {1'b0, r_dsor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_dsor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? DW'(trial - {1'b0, r_dsor}) : trial[DW-1:0];
            r_quo <= {r_quo[NW-2:0], fits};
        end
    end

    assign o_ctl.start = 1'b0;
    assign o_ctl.done  = r_done;
    assign o_quotient  = r_quo;
endmodule

[design/fuzzy_heater_power_controller_top.sv]
// Top level: sequencer, controller state, limit path and output register.
// Depends on fhpc_pkg and fhpc_divider.
//
//  channel | direction | handshake                  | payload
//  input   | in        | i_in_valid / o_in_stall    | operation, error, flow, outlet, pump, warm
//  output  | out       | o_out_valid / i_out_stall  | heater_power, pump_step_down
//  config  | in        | i_cfg_valid / o_cfg_ready  | index, data
//
// An update tick steps IDLE, PREP, MODE, OUT; every fifth tick adds DIV and ACC after PREP,
// where the bit-serial divider converts the fuzzy step. Init steps IDLE, PREP, OUT.
// Synchronous active-low reset; no clearing pass. A finished word waits in the
// output register while the next word is accepted; a stalled output holds the
// sequencer in its last step.
module fuzzy_heater_power_controller_top
    import fhpc_pkg::*;
#(
    parameter int ACC_FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic signed [11:0] i_error,
    input  logic [2:0]         i_flow_level,
    input  logic signed [11:0] i_outlet_temp,
    input  logic [3:0]         i_pump_level,
    input  logic               i_outlet_above_setpoint,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_heater_power,
    output logic               o_pump_step_down,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [11:0]        i_cfg_data
);
    localparam int F   = ACC_FRAC_BITS;
    localparam int AW  = 8 + F;
    localparam int NDW = 20 + F;
    localparam int DVW = DSR_W + 1;
    localparam int SW  = NDW + 2;
    localparam logic [AW-1:0] FX_MAX = {8'd255, {F{1'b0}}};
    localparam logic [AW-1:0] FX_207 = {8'd207, {F{1'b0}}};
    localparam logic [AW-1:0] FX_192 = {8'd192, {F{1'b0}}};
    localparam logic [AW-1:0] FX_128 = {8'd128, {F{1'b0}}};
    localparam logic [AW-1:0] FX_96  = {8'd96, {F{1'b0}}};
    localparam logic [AW-1:0] FX_48  = {8'd48, {F{1'b0}}};

    t_state r_state, n_state;

    logic [7:0]         r_lim_no, r_lim_low, r_lim_mid;
    logic signed [11:0] r_hot;

    logic               r_op, r_warm;
    logic signed [11:0] r_err;
    logic [2:0]         r_flow;
    logic signed [11:0] r_outlet;
    logic [3:0]         r_pump;

    logic [2:0]  r_tick, n_tick;
    logic [7:0]  r_sat, n_sat;
    t_mode       r_mode, n_mode;
    logic [7:0]  r_gain, n_gain;
    logic [7:0]  r_last, n_last;
    logic [AW-1:0] r_acc, n_acc;
    logic [7:0]  r_lim, n_lim;
    logic [7:0]  r_val, n_val;
    logic        r_neg, n_neg;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_power, n_power;
    logic        r_step, n_step;

    t_fuzzy        fz;
    t_div_ctl      div_in, div_out;
    logic [NDW-1:0] quotient;
    logic          accept, out_free, fuzzy_tick;
    logic [2:0]    tick_inc;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign tick_inc = r_tick + 3'd1;
    assign fuzzy_tick = tick_inc >= 3'd5;
    assign fz = fuzzy_num(r_err);

    assign div_in.start = (r_state == ST_PREP) && !r_op && fuzzy_tick;
    assign div_in.done  = 1'b0;

    fhpc_divider #(
        .NW (NDW),
        .DW (DVW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_in),
        .i_dividend (NDW'({fz.mag, {F{1'b0}}, 1'b0}) + NDW'(fz.dsor)),
        .i_divisor  ({fz.dsor, 1'b0}),
        .o_ctl      (div_out),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_no  <= 8'd0;
            r_lim_low <= 8'd144;
            r_lim_mid <= 8'd254;
            r_hot     <= 12'sd600;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LIMIT_NO_FLOW:  r_lim_no  <= i_cfg_data[7:0];
                CFG_LIMIT_LOW_FLOW: r_lim_low <= i_cfg_data[7:0];
                CFG_LIMIT_MID_FLOW: r_lim_mid <= i_cfg_data[7:0];
                CFG_HOT_THRESHOLD:  r_hot     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_operation;
            r_err    <= i_error;
            r_flow   <= i_flow_level;
            r_outlet <= i_outlet_temp;
            r_pump   <= i_pump_level;
            r_warm   <= i_outlet_above_setpoint;
        end
        r_lim   <= n_lim;
        r_val   <= n_val;
        r_neg   <= n_neg;
        r_power <= n_power;
        r_step  <= n_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tick      <= 3'd0;
            r_sat       <= 8'd0;
            r_mode      <= MODE_IDLE;
            r_gain      <= 8'd128;
            r_last      <= 8'd0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tick      <= n_tick;
            r_sat       <= n_sat;
            r_mode      <= n_mode;
            r_gain      <= n_gain;
            r_last      <= n_last;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_PREP;
            ST_PREP: begin
                priority if (r_op)     n_state = ST_OUT;
                else if (fuzzy_tick)   n_state = ST_DIV;
                else                   n_state = ST_MODE;
            end
            ST_DIV:  if (div_out.done) n_state = ST_ACC;
            ST_ACC:  n_state = ST_MODE;
            ST_MODE: n_state = ST_OUT;
            ST_OUT:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        logic signed [16:0] chg;
        logic signed [17:0] lim_sum;
        logic [7:0]         base;
        logic signed [SW-1:0] acc_sum;
        logic [AW:0]        gsum;
        logic [AW-1:0]      gain_fx;
        logic [AW-1:0]      acc_m;
        logic [7:0]         sat_inc;
        n_tick      = r_tick;
        n_sat       = r_sat;
        n_mode      = r_mode;
        n_gain      = r_gain;
        n_last      = r_last;
        n_acc       = r_acc;
        n_lim       = r_lim;
        n_val       = r_val;
        n_neg       = r_neg;
        n_power     = r_power;
        n_step      = r_step;
        n_out_valid = r_out_valid && i_out_stall;
        chg         = 17'sd5 * (17'(r_err) - 17'(signed'(r_last)));
        base = 8'd255;
        if (r_flow == 3'd0) begin
            base = r_lim_no;
        end else if (r_flow < 3'd3 && r_outlet > r_hot) begin
            base = (r_flow == 3'd1) ? r_lim_low : r_lim_mid;
        end
        lim_sum = 18'(signed'({1'b0, base})) + 18'(chg);
        acc_sum = r_neg ? SW'(r_acc) - SW'(quotient) : SW'(r_acc) + SW'(quotient);
        gain_fx = {r_gain, {F{1'b0}}};
        acc_m   = r_acc;
        gsum    = {1'b0, r_acc} + {1'b0, gain_fx};
        sat_inc = r_sat + 8'd1;
        unique case (r_state)
            ST_PREP: begin
                if (r_op) begin
                    n_tick = 3'd0;
                    n_sat  = 8'd0;
                    n_mode = MODE_IDLE;
                    n_last = 8'd0;
                    n_gain = r_warm ? 8'd16 : 8'd128;
                    n_acc  = r_warm ? FX_128 : '0;
                    n_val  = 8'd0;
                    n_lim  = 8'd0;
                end else begin
                    n_last = r_err[7:0];
                    n_neg  = fz.neg;
                    n_tick = fuzzy_tick ? 3'd0 : tick_inc;
                    priority if (lim_sum > 18'sd255) n_lim = 8'd255;
                    else if (lim_sum < 18'sd0)       n_lim = 8'd0;
                    else                             n_lim = lim_sum[7:0];
                end
            end
            ST_ACC: begin
                priority if (acc_sum < 0)            n_acc = '0;
                else if (acc_sum > SW'(FX_MAX))      n_acc = FX_MAX;
                else                                 n_acc = acc_sum[AW-1:0];
            end
            ST_MODE: begin
                priority if (r_err > 12'sd50) begin
                    if (r_mode != MODE_BOOST) begin
                        n_mode = MODE_BOOST;
                        if (r_acc < FX_192) begin
                            acc_m = (gsum > {1'b0, FX_MAX}) ? FX_MAX : gsum[AW-1:0];
                        end
                    end
                    n_val = (r_err > 12'sd150 || acc_m > FX_207) ? 8'd255
                          : acc_m[AW-1:F] + 8'd48;
                end else if (r_err < -12'sd50) begin
                    if (r_mode != MODE_CUT) begin
                        n_mode = MODE_CUT;
                        if (r_acc > FX_96) begin
                            acc_m = (r_acc > gain_fx) ? r_acc - gain_fx : '0;
                        end
                    end
                    n_val = (r_err < -12'sd150 || acc_m < FX_48) ? 8'd0
                          : acc_m[AW-1:F] - 8'd48;
                end else begin
                    if (r_mode == MODE_BOOST || r_mode == MODE_CUT) begin
                        n_mode = MODE_RECOVERED;
                        n_gain = {1'b0, r_gain[7:1]};
                    end
                    n_val = r_acc[AW-1:F];
                end
                n_acc = acc_m;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_step      = 1'b0;
                    n_power     = (r_val < r_lim) ? r_val : r_lim;
                    if (!r_op) begin
                        if (r_val == 8'd255) begin
                            n_sat = sat_inc;
                            if (sat_inc == 8'd0 && r_pump > 4'd2) begin
                                n_step = 1'b1;
                                n_acc  = FX_192;
                                n_gain = 8'd32;
                            end
                        end else if (r_sat > 8'd0) begin
                            n_sat = r_sat - 8'd1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_heater_power   = r_power;
    assign o_pump_step_down = r_step;
endmodule

[design/fhpc_checker.sv]
// Port-level checks for the fuzzy heater power controller, bound to the top level.
// Depends on fuzzy_heater_power_controller_top port names.
module fhpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_heater_power,
    input logic        o_pump_step_down
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_heater_power)
            && $stable(o_pump_step_down))
        else $error("stalled output word changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset left word pending or busy");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not held off while word in work");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after accept");
endmodule

bind fuzzy_heater_power_controller_top fhpc_checker u_fhpc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_heater_power   (o_heater_power),
    .o_pump_step_down (o_pump_step_down)
);
